### hdl/vigenere_printable_ascii_decoder_core_macros.svh
// ---------------------------------------------------------------------------
// vigenere decoder assertion macros
// shared concurrent assertion forms for the decoder checker
// ---------------------------------------------------------------------------
`ifndef VIGENERE_PRINTABLE_ASCII_DECODER_CORE_MACROS_SVH
`define VIGENERE_PRINTABLE_ASCII_DECODER_CORE_MACROS_SVH

// same-cycle implication, clock and reset taken from the enclosing scope
`define VIGDEC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vigdec assertion failed");

// next-cycle implication
`define VIGDEC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vigdec assertion failed");

`endif

### hdl/vigdec_pkg.sv
// ---------------------------------------------------------------------------
// vigdec_pkg
// widths, register indexes and the byte transform of the vigenere decoder
// ---------------------------------------------------------------------------
package vigdec_pkg;

	localparam int KEY_BYTES  = 16;
	localparam int POS_W      = $clog2(KEY_BYTES);
	localparam int LEN_W      = POS_W + 1;
	localparam int BYTE_W     = 8;
	localparam int KEY_LEN_W  = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;

	localparam logic [BYTE_W-1:0] ALPHA_LO = 8'd32;
	localparam logic [BYTE_W-1:0] ALPHA_HI = 8'd127;

	localparam logic signed [9:0] DIFF_LO    = 10'sd32;
	localparam logic signed [9:0] ALPHA_SIZE = 10'sd96;
	localparam logic signed [9:0] SHIFT_BIAS = 10'sd31;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KEY_LENGTH     = 2'd0,
		REG_KEY_BYTES_LOW  = 2'd1,
		REG_KEY_BYTES_HIGH = 2'd2
	} cfg_reg_t;

	function automatic logic [BYTE_W-1:0] decipher(input logic [BYTE_W-1:0] c,
	                                               input logic [BYTE_W-1:0] k);
		logic signed [9:0] v;
		logic signed [9:0] w;
		v = signed'({2'b00, c}) + SHIFT_BIAS - signed'({2'b00, k});
		w = (v < DIFF_LO) ? (v + ALPHA_SIZE) : v;
		if (c < ALPHA_LO || c > ALPHA_HI) begin
			return c;
		end
		return w[BYTE_W-1:0];
	endfunction

endpackage

### hdl/vigdec_if.sv
// ---------------------------------------------------------------------------
// vigdec channel interfaces
// ciphertext input, plaintext output and register write channels
// ---------------------------------------------------------------------------
interface vigdec_cipher_if;
	logic                             valid;
	logic                             ready;
	logic [vigdec_pkg::BYTE_W-1:0]    cipher_byte;

	modport source (output valid, output cipher_byte, input ready);
	modport sink   (input valid, input cipher_byte, output ready);
endinterface

interface vigdec_plain_if;
	logic                             valid;
	logic                             ready;
	logic [vigdec_pkg::BYTE_W-1:0]    plain_byte;

	modport source (output valid, output plain_byte, input ready);
	modport sink   (input valid, input plain_byte, output ready);
endinterface

interface vigdec_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [vigdec_pkg::CFG_IDX_W-1:0]    index;
	logic [vigdec_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

### hdl/vigdec_keysched.sv
// ---------------------------------------------------------------------------
// vigdec_keysched
// key registers and running key position; gives the key byte for each word
// ---------------------------------------------------------------------------
module vigdec_keysched (
	input  logic                           clk,
	input  logic                           arst_n,
	vigdec_cfg_if.sink                     cfg,
	input  logic                           advance,
	output logic [vigdec_pkg::BYTE_W-1:0]  key_byte
);
	import vigdec_pkg::*;

	logic [KEY_LEN_W-1:0]  key_length_q;
	logic [CFG_DATA_W-1:0] key_lo_q;
	logic [CFG_DATA_W-1:0] key_hi_q;
	logic [POS_W-1:0]      pos_q;

	logic [LEN_W-1:0]      len;
	logic [POS_W-1:0]      pos_eff;
	logic [LEN_W-1:0]      pos_inc;
	logic [POS_W-1:0]      pos_next;
	logic [2*CFG_DATA_W-1:0] key_all;
	logic [BYTE_W-1:0]     key_arr [KEY_BYTES];

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_length_q <= KEY_LEN_W'(1);
			key_lo_q     <= CFG_DATA_W'(32);
			key_hi_q     <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_KEY_LENGTH:     key_length_q <= cfg.data[KEY_LEN_W-1:0];
				REG_KEY_BYTES_LOW:  key_lo_q     <= cfg.data;
				REG_KEY_BYTES_HIGH: key_hi_q     <= cfg.data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (key_length_q == '0) begin
			len = LEN_W'(1);
		end else if (key_length_q > KEY_LEN_W'(KEY_BYTES)) begin
			len = LEN_W'(KEY_BYTES);
		end else begin
			len = LEN_W'(key_length_q);
		end
	end

	// stale position after a shorter key falls back to byte 0
	assign pos_eff  = ({1'b0, pos_q} >= len) ? '0 : pos_q;
	assign pos_inc  = {1'b0, pos_eff} + LEN_W'(1);
	assign pos_next = (pos_inc >= len) ? '0 : pos_inc[POS_W-1:0];

	assign key_all = {key_hi_q, key_lo_q};

	always_comb begin
		for (int i = 0; i < KEY_BYTES; i++) begin
			key_arr[i] = key_all[i*BYTE_W +: BYTE_W];
		end
	end

	assign key_byte = key_arr[pos_eff];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (advance) begin
			pos_q <= pos_next;
		end
	end

endmodule

### hdl/vigenere_printable_ascii_decoder_core.sv
// ---------------------------------------------------------------------------
// vigenere_printable_ascii_decoder_core
// decodes a vigenere stream over printable ascii, one byte per word
//
//   channel   role    payload              word
//   cipher    sink    cipher_byte [7:0]    one ciphertext byte
//   plain     source  plain_byte  [7:0]    one plaintext byte
//   cfg       sink    index [1:0], data    one register write
//
// one word per cycle sustained while plain is ready; a word passes the input
// register and then the output register before it shows on plain
// the key byte is picked at input accept, the transform sits before the
// output register; ready on the input drops only while both stages are
// full and the output is stalled; cfg is always ready
// reset loads key length 1, key low 32, key high 0, key position 0
// ---------------------------------------------------------------------------
module vigenere_printable_ascii_decoder_core (
	input  logic            clk,
	input  logic            arst_n,
	vigdec_cipher_if.sink   cipher,
	vigdec_plain_if.source  plain,
	vigdec_cfg_if.sink      cfg
);
	import vigdec_pkg::*;

	logic              valid_s1;
	logic              valid_s2;
	logic [BYTE_W-1:0] byte_s1;
	logic [BYTE_W-1:0] key_s1;
	logic [BYTE_W-1:0] byte_s2;
	logic [BYTE_W-1:0] key_byte;
	logic              adv_s2;
	logic              acc;

	assign adv_s2       = !valid_s2 || plain.ready;
	assign cipher.ready = !valid_s1 || adv_s2;
	assign acc          = cipher.valid && cipher.ready;

	vigdec_keysched u_keysched (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.advance  (acc),
		.key_byte (key_byte)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (acc) begin
				valid_s1 <= 1'b1;
			end else if (adv_s2) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			byte_s1 <= cipher.cipher_byte;
			key_s1  <= key_byte;
		end
		if (adv_s2 && valid_s1) begin
			byte_s2 <= decipher(byte_s1, key_s1);
		end
	end

	assign plain.valid      = valid_s2;
	assign plain.plain_byte = byte_s2;

endmodule

### hdl/vigdec_checker.sv
// ---------------------------------------------------------------------------
// vigdec_checker
// port-level checks on the decoder, bound to vigenere_printable_ascii_decoder_core
// ---------------------------------------------------------------------------
`include "vigenere_printable_ascii_decoder_core_macros.svh"

module vigdec_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic [vigdec_pkg::BYTE_W-1:0]  in_byte,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [vigdec_pkg::BYTE_W-1:0]  out_byte
);
	import vigdec_pkg::*;

	logic in_acc;
	logic in_pass;

	assign in_acc  = in_valid && in_ready;
	assign in_pass = in_acc && (in_byte < ALPHA_LO || in_byte > ALPHA_HI);

	`VIGDEC_ASSERT_NXT(a_out_valid_hold, out_valid && !out_ready, out_valid)
	`VIGDEC_ASSERT_NXT(a_out_byte_hold, out_valid && !out_ready, $stable(out_byte))
	`VIGDEC_ASSERT_IMP(a_out_from_input, $rose(out_valid), $past(in_acc, 2))
	`VIGDEC_ASSERT_NXT(a_passthru, in_pass ##1 out_ready, out_valid && out_byte == $past(in_byte, 2))

endmodule

bind vigenere_printable_ascii_decoder_core vigdec_checker u_vigdec_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (cipher.valid),
	.in_ready  (cipher.ready),
	.in_byte   (cipher.cipher_byte),
	.out_valid (plain.valid),
	.out_ready (plain.ready),
	.out_byte  (plain.plain_byte)
);

### verif/vigdec_plain_check.sv
// ---------------------------------------------------------------------------
// vigdec_plain_check
// watches the cipher, plain and register channels of the decoder, keeps its
// own key, key length and key position, works out the plaintext byte of every
// accepted cipher word and compares it with the plain words in order
// ---------------------------------------------------------------------------
module vigdec_plain_check (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cipher_valid,
	input  logic                              cipher_ready,
	input  logic [vigdec_pkg::BYTE_W-1:0]     cipher_byte,
	input  logic                              plain_valid,
	input  logic                              plain_ready,
	input  logic [vigdec_pkg::BYTE_W-1:0]     plain_byte,
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic [vigdec_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [vigdec_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                                failures,
	output int                                pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import vigdec_pkg::*;

	localparam int KEY_BIAS = 31;
	localparam int ALPHABET = 96;

	logic [KEY_LEN_W-1:0]  key_len;
	logic [CFG_DATA_W-1:0] key_lo;
	logic [CFG_DATA_W-1:0] key_hi;
	logic [POS_W-1:0]      key_pos;
	logic [BYTE_W-1:0]     plain_due[$];

	function automatic logic [BYTE_W-1:0] plain_of(input logic [BYTE_W-1:0] c,
	                                               input logic [BYTE_W-1:0] k);
		int v;
		if (c < ALPHA_LO || c > ALPHA_HI) begin
			return c;
		end
		v = int'(c) + KEY_BIAS - int'(k);
		if (v < int'(ALPHA_LO)) begin
			v = v + ALPHABET;
		end
		return v[BYTE_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		int span;
		int slot;
		logic [BYTE_W-1:0] kb;
		logic [BYTE_W-1:0] want;
		if (!arst_n) begin
			key_len = KEY_LEN_W'(1);
			key_lo  = 64'd32;
			key_hi  = 64'd0;
			key_pos = '0;
			plain_due.delete();
			pending = 0;
		end else begin
			// a word accepted with a register write still sees the old key
			if (cipher_valid && cipher_ready) begin
				span = (key_len == 0) ? 1 : ((key_len > KEY_BYTES) ? KEY_BYTES : int'(key_len));
				slot = (int'(key_pos) >= span) ? 0 : int'(key_pos);
				kb = (slot < 8) ? key_lo[slot*8 +: 8] : key_hi[(slot-8)*8 +: 8];
				plain_due.push_back(plain_of(cipher_byte, kb));
				slot = slot + 1;
				key_pos = (slot >= span) ? '0 : slot[POS_W-1:0];
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_KEY_LENGTH:     key_len = cfg_data[KEY_LEN_W-1:0];
					REG_KEY_BYTES_LOW:  key_lo  = cfg_data;
					REG_KEY_BYTES_HIGH: key_hi  = cfg_data;
					default: ;
				endcase
			end
			if (plain_valid && plain_ready) begin
				if (plain_due.size() == 0) begin
					$error("plain_byte: no word expected, actual 0x%02h", plain_byte);
					failures++;
				end else begin
					want = plain_due.pop_front();
					if (plain_byte !== want) begin
						$error("plain_byte: expected 0x%02h, actual 0x%02h", want, plain_byte);
						failures++;
					end
				end
			end
			pending = plain_due.size();
		end
	end

endmodule

### verif/vigenere_printable_ascii_decoder_core_test.sv
// ---------------------------------------------------------------------------
// vigenere_printable_ascii_decoder_core_test
// drives cipher words in bursts against a stalling plain receiver, rewrites
// key length and key bytes between phases, and takes the verdict from
// vigdec_plain_check
// ---------------------------------------------------------------------------
module vigenere_printable_ascii_decoder_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import vigdec_pkg::*;

	localparam int                   IDLE_LIMIT     = 2000;
	localparam int                   HOLD_CYCLES    = 80;
	localparam int                   RANDOM_WORDS   = 1350;
	localparam logic [CFG_IDX_W-1:0] REG_UNASSIGNED = 2'd3;

	logic clk;
	logic arst_n;
	int   failures;
	int   pending;
	int   idle_cycles;
	bit   hold_request;

	vigdec_cipher_if cipher_ch();
	vigdec_plain_if  plain_ch();
	vigdec_cfg_if    cfg_ch();

	vigenere_printable_ascii_decoder_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cipher (cipher_ch),
		.plain  (plain_ch),
		.cfg    (cfg_ch)
	);

	vigdec_plain_check scoreboard (
		.clk          (clk),
		.arst_n       (arst_n),
		.cipher_valid (cipher_ch.valid),
		.cipher_ready (cipher_ch.ready),
		.cipher_byte  (cipher_ch.cipher_byte),
		.plain_valid  (plain_ch.valid),
		.plain_ready  (plain_ch.ready),
		.plain_byte   (plain_ch.plain_byte),
		.cfg_valid    (cfg_ch.valid),
		.cfg_ready    (cfg_ch.ready),
		.cfg_index    (cfg_ch.index),
		.cfg_data     (cfg_ch.data),
		.failures     (failures),
		.pending      (pending)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if ((cipher_ch.valid && cipher_ch.ready) || (plain_ch.valid && plain_ch.ready) ||
		    (cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("vigenere_printable_ascii_decoder_core_test: done, errors");
			$finish;
		end
	end

	// receiver stall patterns, plus one long hold on request
	initial begin : receiver
		int mode;
		int span;
		int tick;
		plain_ch.ready = 1'b0;
		tick = 0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(20, 200);
			repeat (span) begin
				@(negedge clk);
				if (hold_request) begin
					plain_ch.ready <= 1'b0;
					repeat (HOLD_CYCLES) @(negedge clk);
					hold_request = 1'b0;
				end
				case (mode)
					0: plain_ch.ready <= 1'b1;
					1: plain_ch.ready <= 1'($urandom_range(0, 1));
					2: plain_ch.ready <= ($urandom_range(0, 7) == 0);
					default: plain_ch.ready <= ((tick % 5) < 3);
				endcase
				tick++;
			end
		end
	end

	task automatic send_cipher(input logic [BYTE_W-1:0] b);
		cipher_ch.cipher_byte <= b;
		cipher_ch.valid <= 1'b1;
		@(posedge clk);
		while (!cipher_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic pause_cipher(input int cycles);
		cipher_ch.valid <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		cfg_ch.valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic drain;
		while (pending != 0) @(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic send_directed(input logic [BYTE_W-1:0] bs[]);
		foreach (bs[i]) send_cipher(bs[i]);
		cipher_ch.valid <= 1'b0;
		drain();
	endtask

	function automatic logic [CFG_DATA_W-1:0] random_key();
		logic [CFG_DATA_W-1:0] k;
		if ($urandom_range(0, 2) == 0) begin
			k = {$urandom, $urandom};
		end else begin
			for (int i = 0; i < 8; i++) k[i*8 +: 8] = 8'($urandom_range(32, 127));
		end
		return k;
	endfunction

	function automatic logic [KEY_LEN_W-1:0] random_length();
		case ($urandom_range(0, 7))
			0: return 5'd0;
			1: return 5'd1;
			2: return 5'd16;
			3: return 5'd31;
			4: return 5'd17;
			default: return 5'($urandom_range(0, 31));
		endcase
	endfunction

	task automatic random_run(input int count, input bit gappy);
		int left;
		logic [BYTE_W-1:0] b;
		left = $urandom_range(1, 20);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 9) < 8) begin
				b = 8'($urandom_range(32, 127));
			end else begin
				b = 8'($urandom_range(0, 255));
			end
			send_cipher(b);
			left--;
			if (gappy && left == 0) begin
				pause_cipher($urandom_range(1, 6));
				left = $urandom_range(1, 20);
			end
		end
		cipher_ch.valid <= 1'b0;
	endtask

	initial begin : stimulus
		int sent;
		int count;
		hold_request = 1'b0;
		arst_n = 1'b0;
		cipher_ch.valid = 1'b0;
		cipher_ch.cipher_byte = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset key, bytes outside the alphabet and its edges
		send_directed('{8'd0, 8'd31, 8'd32, 8'd33, 8'd127, 8'd128, 8'd255});

		// key bytes 0x20, 0x00, 0xff, 0x7f: zero, negative and large shifts
		write_reg(REG_KEY_LENGTH, 64'd4);
		write_reg(REG_KEY_BYTES_LOW, 64'h0123_4567_7fff_0020);
		write_reg(REG_KEY_BYTES_HIGH, 64'hffff_ffff_ffff_ffff);
		send_directed('{8'd32, 8'd127, 8'd32, 8'd127, 8'd64, 8'd200});

		write_reg(REG_KEY_LENGTH, 64'd16);
		send_directed('{8'd127, 8'd32, 8'd90, 8'd127, 8'd45});

		// position left beyond a shortened key
		write_reg(REG_KEY_LENGTH, 64'd2);
		send_directed('{8'd100, 8'd100});
		write_reg(REG_KEY_LENGTH, 64'd0);
		write_reg(REG_UNASSIGNED, 64'hffff_ffff_ffff_ffff);
		send_directed('{8'd32, 8'd127});
		write_reg(REG_KEY_LENGTH, 64'hffff_ffff_ffff_ffff);
		send_directed('{8'd33, 8'd126});

		// long receiver hold while the sender keeps offering
		write_reg(REG_KEY_LENGTH, 64'd16);
		write_reg(REG_KEY_BYTES_LOW, random_key());
		write_reg(REG_KEY_BYTES_HIGH, random_key());
		hold_request = 1'b1;
		random_run(100, 1'b0);
		drain();
		sent = 100;

		while (sent < RANDOM_WORDS) begin
			write_reg(REG_KEY_LENGTH, 64'(random_length()));
			if ($urandom_range(0, 9) < 7) write_reg(REG_KEY_BYTES_LOW, random_key());
			if ($urandom_range(0, 9) < 7) write_reg(REG_KEY_BYTES_HIGH, random_key());
			if ($urandom_range(0, 9) == 0) write_reg(REG_UNASSIGNED, {$urandom, $urandom});
			count = $urandom_range(60, 150);
			random_run(count, $urandom_range(0, 3) != 0);
			drain();
			sent += count;
		end

		repeat (8) @(negedge clk);
		if (failures == 0) begin
			$display("vigenere_printable_ascii_decoder_core_test: done, clean");
		end else begin
			$display("vigenere_printable_ascii_decoder_core_test: done, errors");
		end
		$finish;
	end

endmodule
